>>> src/assert_macros.svh
// concurrent assertion helpers, clocked on i_clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int FIELD_BITS  = 16;
    localparam int NUM_BITS    = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam int STEP_W      = $clog2(NUM_BITS);
    localparam int DIGIT_SLOTS = 16;
    localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);
    localparam int STACK_W     = DIGIT_SLOTS * 4;

    localparam logic [7:0] RADIX_MIN   = 8'd2;
    localparam logic [7:0] RADIX_MAX   = 8'd16;
    localparam logic [7:0] RADIX_RESET = 8'd10;

    localparam logic [6:0] ASCII_ZERO = 7'h30;
    localparam logic [6:0] ASCII_A    = 7'h41;

    typedef logic [6:0] t_char;

    function automatic t_char digit_ascii(input logic [3:0] d);
        t_char c;
        if (d < 4'd10) begin
            c = ASCII_ZERO + {3'b000, d};
        end else begin
            c = ASCII_A + {3'b000, d - 4'd10};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/itoa_in_if.sv
`default_nettype none

interface itoa_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

>>> src/itoa_out_if.sv
`default_nettype none

interface itoa_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] digit_char;
    logic       is_last;
    logic       is_empty;

    modport source (output valid, output digit_char, output is_last, output is_empty,
                    input ready);
    modport sink   (input valid, input digit_char, input is_last, input is_empty,
                    output ready);
endinterface

`default_nettype wire

>>> src/itoa_cfg_if.sv
`default_nettype none

interface itoa_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/integer_to_ascii_radix.sv
// integer_to_ascii_radix: writes an unsigned number as ASCII digits in radix 2..16
// channels: i_in_ch takes one number per item, o_out_ch gives one character per
// item, most significant digit first, with is_last on the final character.
// i_cfg_ch writes the radix register (always ready, reset value 10); write it
// only while the block is idle. a radix outside 2..16 gives one item with
// is_empty and is_last set and digit_char zero. zero converts to a single '0'.
// timing: one restoring divider, one quotient bit per cycle, is shared by all
// digits; all digits of a number are divided out before the first is output.
// the input is not ready from acceptance until the last character is taken.
// a stalled receiver simply holds the current character; nothing is lost.
// reset (synchronous, active low) returns to idle and sets the radix to 10.
`default_nettype none
`include "assert_macros.svh"

module integer_to_ascii_radix
    import itoa_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    itoa_cfg_if.sink   i_cfg_ch,
    itoa_in_if.sink    i_in_ch,
    itoa_out_if.source o_out_ch
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [7:0]          r_radix;
    logic [4:0]          r_div, n_div;
    logic [NUM_BITS-1:0] r_quo, n_quo;
    logic [3:0]          r_rem, n_rem;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [STACK_W-1:0]  r_stack, n_stack;
    logic                r_empty, n_empty;

    logic [4:0]          trial;
    logic                fits;
    logic [3:0]          rem_step;
    logic [NUM_BITS-1:0] quo_step;
    logic                radix_ok;
    logic                in_acc, out_acc;

    assign i_cfg_ch.ready = 1'b1;

    assign i_in_ch.ready       = (r_state == S_IDLE);
    assign o_out_ch.valid      = (r_state == S_EMIT);
    assign o_out_ch.digit_char = r_empty ? 7'd0 : digit_ascii(r_stack[3:0]);
    assign o_out_ch.is_last    = (r_cnt == CNT_W'(1));
    assign o_out_ch.is_empty   = r_empty;

    assign in_acc   = i_in_ch.valid && i_in_ch.ready;
    assign out_acc  = o_out_ch.valid && o_out_ch.ready;
    assign radix_ok = (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX);

    // one restoring division step
    assign trial    = {r_rem, r_quo[NUM_BITS-1]};
    assign fits     = (trial >= r_div);
    assign rem_step = fits ? 4'(trial - r_div) : trial[3:0];
    assign quo_step = {r_quo[NUM_BITS-2:0], fits};

    always_comb begin
        n_state = r_state;
        n_div   = r_div;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_stack = r_stack;
        n_empty = r_empty;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_div   = r_radix[4:0];
                    n_quo   = NUM_BITS'(i_in_ch.value);
                    n_rem   = 4'd0;
                    n_step  = '0;
                    n_stack = '0;
                    if (radix_ok) begin
                        n_empty = 1'b0;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end else begin
                        n_empty = 1'b1;
                        n_cnt   = CNT_W'(1);
                        n_state = S_EMIT;
                    end
                end
            end
            S_DIV: begin
                n_quo = quo_step;
                n_rem = rem_step;
                if (r_step == STEP_W'(NUM_BITS - 1)) begin
                    // digit done: push remainder, go on with the quotient
                    n_stack = {r_stack[STACK_W-5:0], rem_step};
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_rem   = 4'd0;
                    n_step  = '0;
                    if (quo_step == '0 || n_cnt == CNT_W'(DIGIT_SLOTS)) begin
                        n_state = S_EMIT;
                    end
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_EMIT: begin
                if (out_acc) begin
                    n_stack = {4'd0, r_stack[STACK_W-1:4]};
                    n_cnt   = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_radix <= RADIX_RESET;
            r_cnt   <= '0;
            r_step  <= '0;
            r_empty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_empty <= n_empty;
            if (i_cfg_ch.valid && i_cfg_ch.ready) begin
                r_radix <= i_cfg_ch.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_div   <= n_div;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_stack <= n_stack;
    end

    `ASSERT_IMPL(a_no_overlap, i_in_ch.ready, !o_out_ch.valid)
    `ASSERT_NEXT(a_last_frees_input, out_acc && o_out_ch.is_last, i_in_ch.ready)
    `ASSERT_IMPL(a_empty_is_last, o_out_ch.valid && o_out_ch.is_empty, o_out_ch.is_last)
    `ASSERT_IMPL(a_cnt_bound, r_state == S_EMIT,
                 r_cnt != CNT_W'(0) && r_cnt <= CNT_W'(DIGIT_SLOTS))

endmodule

`default_nettype wire

>>> tb/sv/integer_to_ascii_radix_test.sv
`timescale 1ns / 100ps

module integer_to_ascii_radix_test;
    import itoa_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef enum logic [1:0] {
        STIM_NUMBER,
        STIM_RADIX,
        STIM_DRAIN
    } t_stim_kind;

    typedef struct {
        t_stim_kind  kind;
        logic [15:0] word;
    } t_stim;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       is_last;
        logic       is_empty;
    } t_glyph;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    itoa_cfg_if cfg_ch ();
    itoa_in_if  in_ch ();
    itoa_out_if out_ch ();

    integer_to_ascii_radix uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg_ch(cfg_ch),
        .i_in_ch (in_ch),
        .o_out_ch(out_ch)
    );

    t_stim      pending[$];
    t_glyph     owed_chars[$];
    int         owed_count = 0;
    logic [7:0] held_radix = RADIX_RESET;
    int         gap_left = 0;
    int         send_calm = 0;
    int         recv_calm = 0;
    int         stall_left = 0;
    int         mismatches = 0;
    int         numbers_taken = 0;
    int         chars_checked = 0;
    int         empties_seen = 0;
    int         radix_writes = 0;
    int         cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones, and calm stretches with none
    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (r < 5) begin
            calm = $urandom_range(20, 50);
            return 0;
        end
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // expected characters of one number, most significant digit first
    task automatic spell_in_radix(input logic [15:0] number, input logic [7:0] base);
        logic [3:0]  digs[$];
        int unsigned n;
        int unsigned b;
        t_glyph      g;
        n = number;
        b = base;
        if (base < RADIX_MIN || base > RADIX_MAX) begin
            g.digit_char = 7'd0;
            g.is_last    = 1'b1;
            g.is_empty   = 1'b1;
            owed_chars.push_back(g);
            return;
        end
        do begin
            digs.push_front(4'(n % b));
            n = n / b;
        end while (n != 0);
        for (int k = 0; k < digs.size(); k++) begin
            if (digs[k] < 4'd10) begin
                g.digit_char = ASCII_ZERO + 7'(digs[k]);
            end else begin
                g.digit_char = ASCII_A + 7'(digs[k] - 4'd10);
            end
            g.is_last  = (k == digs.size() - 1);
            g.is_empty = 1'b0;
            owed_chars.push_back(g);
        end
    endtask

    task automatic add_number(input logic [15:0] v);
        pending.push_back('{kind: STIM_NUMBER, word: v});
    endtask

    task automatic add_radix(input logic [7:0] r);
        pending.push_back('{kind: STIM_RADIX, word: {8'd0, r}});
    endtask

    task automatic add_drain();
        pending.push_back('{kind: STIM_DRAIN, word: 16'd0});
    endtask

    function automatic logic [7:0] random_radix();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: begin
                return RADIX_MIN;
            end
            1: begin
                return RADIX_MAX;
            end
            2: begin
                return RADIX_RESET;
            end
            3: begin
                return 8'($urandom_range(0, 1));
            end
            4: begin
                return 8'($urandom_range(17, 255));
            end
            default: begin
                return 8'($urandom_range(2, 16));
            end
        endcase
    endfunction

    function automatic logic [15:0] random_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                return 16'd0;
            end
            1: begin
                return 16'hFFFF;
            end
            2: begin
                return 16'($urandom_range(1, 20));
            end
            3: begin
                return 16'((1 << $urandom_range(0, 15)) - $urandom_range(0, 1));
            end
            default: begin
                return 16'($urandom_range(0, 65535));
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : driver
        logic        next_in_valid;
        logic [15:0] next_value;
        logic        next_cfg_valid;
        logic [7:0]  next_radix;
        next_in_valid  = in_ch.valid;
        next_value     = in_ch.value;
        next_cfg_valid = cfg_ch.valid;
        next_radix     = cfg_ch.data;
        if (!i_rst_n) begin
            next_in_valid  = 1'b0;
            next_cfg_valid = 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                next_in_valid = 1'b0;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                next_cfg_valid = 1'b0;
            end
            if (!next_in_valid && !next_cfg_valid && pending.size() != 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending[0].kind == STIM_NUMBER) begin
                    next_in_valid = 1'b1;
                    next_value    = pending[0].word;
                    void'(pending.pop_front());
                    gap_left = pick_gap(send_calm);
                end else if (!in_ch.valid && owed_count == 0) begin
                    // radix writes and drains only once the block is idle
                    if (pending[0].kind == STIM_RADIX) begin
                        next_cfg_valid = 1'b1;
                        next_radix     = pending[0].word[7:0];
                    end
                    void'(pending.pop_front());
                end
            end
        end
        in_ch.valid  <= next_in_valid;
        in_ch.value  <= next_value;
        cfg_ch.valid <= next_cfg_valid;
        cfg_ch.data  <= next_radix;
    end

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap(recv_calm);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_glyph want;
        if (!i_rst_n) begin
            held_radix = RADIX_RESET;
            owed_chars.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                held_radix = cfg_ch.data;
                radix_writes++;
            end
            if (in_ch.valid && in_ch.ready) begin
                spell_in_radix(in_ch.value, held_radix);
                numbers_taken++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (owed_chars.size() == 0) begin
                    $display("%0t: unexpected item char %h last %b empty %b", $time,
                             out_ch.digit_char, out_ch.is_last, out_ch.is_empty);
                    mismatches++;
                end else begin
                    want = owed_chars.pop_front();
                    chars_checked++;
                    if (want.is_empty) begin
                        empties_seen++;
                    end
                    if (out_ch.digit_char !== want.digit_char) begin
                        $display("%0t: digit_char expected %h got %h", $time,
                                 want.digit_char, out_ch.digit_char);
                        mismatches++;
                    end
                    if (out_ch.is_last !== want.is_last) begin
                        $display("%0t: is_last expected %b got %b", $time,
                                 want.is_last, out_ch.is_last);
                        mismatches++;
                    end
                    if (out_ch.is_empty !== want.is_empty) begin
                        $display("%0t: is_empty expected %b got %b", $time,
                                 want.is_empty, out_ch.is_empty);
                        mismatches++;
                    end
                end
            end
        end
        owed_count <= owed_chars.size();
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d items still pending", $time, pending.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int          planned;
        int          run_len;
        logic [7:0]  base;
        in_ch.valid  = 1'b0;
        in_ch.value  = 16'd0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = 8'd0;
        out_ch.ready = 1'b0;

        // reset radix
        add_number(16'd0);
        add_number(16'hFFFF);
        add_number(16'd1);
        add_number(16'd9);
        add_number(16'd10);
        add_number(16'd12345);
        add_drain();
        add_radix(RADIX_MAX);
        add_number(16'hFFFF);
        add_number(16'hABCD);
        add_number(16'd0);
        add_number(16'd15);
        add_radix(RADIX_MIN);
        add_number(16'hFFFF);
        add_number(16'h8000);
        add_number(16'd0);
        // invalid radix values, then radix 3 and the reset radix again
        add_radix(8'd0);
        add_number(16'd1234);
        add_radix(8'd1);
        add_number(16'd5);
        add_radix(8'd17);
        add_number(16'd99);
        add_radix(8'd255);
        add_number(16'd0);
        add_radix(8'd3);
        add_number(16'hFFFF);
        add_radix(RADIX_RESET);
        add_number(16'd100);

        planned = 0;
        while (planned < 140) begin
            base = random_radix();
            add_radix(base);
            run_len = $urandom_range(6, 20);
            for (int i = 0; i < run_len; i++) begin
                add_number(random_value());
                planned++;
                if ($urandom_range(0, 29) == 0) begin
                    add_drain();
                end
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample between edges so every handshake update has settled
        while (pending.size() != 0 || in_ch.valid || cfg_ch.valid || owed_count != 0) begin
            @(negedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (owed_chars.size() != 0) begin
            $display("%0t: %0d expected items never arrived", $time, owed_chars.size());
            mismatches++;
        end
        $display("converted %0d numbers under %0d radix writes, valid and invalid bases",
                 numbers_taken, radix_writes);
        $display("checked %0d characters, %0d of them empty markers, %0d mismatches",
                 chars_checked, empties_seen, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/itoa_pkg.sv
src/itoa_in_if.sv
src/itoa_out_if.sv
src/itoa_cfg_if.sv
src/integer_to_ascii_radix.sv
tb/sv/integer_to_ascii_radix_test.sv
